[sv/prqs_pkg.sv]
// Shared constants, codes and types of the priority ready-queue scheduler.
package prqs_pkg;

    // Sizing of the scheduler tables
    localparam int THREAD_SLOTS    = 8;
    localparam int PRIORITY_LEVELS = 16;

    localparam int SLOT_W = $clog2(THREAD_SLOTS);
    localparam int LINK_W = $clog2(THREAD_SLOTS + 1);
    localparam int PRI_W  = $clog2(PRIORITY_LEVELS);

    // Fixed port field widths
    localparam int OP_W   = 3;
    localparam int PREQ_W = 4;
    localparam int TID_W  = 3;
    localparam int RV_W   = 5;

    // Link value that marks an empty list end
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(THREAD_SLOTS);

    typedef enum logic [OP_W-1:0] {
        OP_RUN     = 3'd0,
        OP_EXIT    = 3'd1,
        OP_WAIT    = 3'd2,
        OP_SLEEP   = 3'd3,
        OP_WAKEUP  = 3'd4,
        OP_GETID   = 3'd5,
        OP_CHPRI   = 3'd6,
        OP_SOFTERR = 3'd7
    } op_t;

    // Commands from the controller to the datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_TAKE,
        CMD_QUEUE_CUR,
        CMD_QUEUE_TGT,
        CMD_QUEUE_NEW,
        CMD_CLEAR_CUR,
        CMD_CREATE,
        CMD_RUN_FAIL,
        CMD_CHPRI,
        CMD_SCAN,
        CMD_LOAD_OUT
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic had_caller;
        logic halted;
        logic free_found;
        logic out_busy;
    } prqs_status_t;

    // Saturate a requested priority to the last level
    function automatic logic [PRI_W-1:0] clamp_pri(input logic [PREQ_W-1:0] p);
        logic [PRI_W-1:0] r;
        if (int'(p) < PRIORITY_LEVELS)
            r = PRI_W'(p);
        else
            r = PRI_W'(PRIORITY_LEVELS - 1);
        return r;
    endfunction

endpackage

[sv/prqs_datapath.sv]
// Scheduler datapath: slot tables, linked priority FIFOs, result and output registers.
module prqs_datapath
    import prqs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output prqs_status_t             status,
    input  logic [OP_W-1:0]          operation,
    input  logic [PREQ_W-1:0]        priority_req,
    input  logic                     priority_given,
    input  logic [TID_W-1:0]         target_thread,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [TID_W-1:0]         next_thread,
    output logic                     thread_valid,
    output logic signed [RV_W-1:0]   result_value,
    output logic                     result_written,
    output logic                     halted
);

    // Slot tables and queue pointers
    logic [THREAD_SLOTS-1:0] in_use_reg, in_use_next;
    logic [THREAD_SLOTS-1:0] ready_reg, ready_next;
    logic [PRI_W-1:0]        pri_reg  [THREAD_SLOTS];
    logic [PRI_W-1:0]        pri_next [THREAD_SLOTS];
    logic [LINK_W-1:0]       link_reg  [THREAD_SLOTS];
    logic [LINK_W-1:0]       link_next [THREAD_SLOTS];
    logic [LINK_W-1:0]       head_reg  [PRIORITY_LEVELS];
    logic [LINK_W-1:0]       head_next [PRIORITY_LEVELS];
    logic [LINK_W-1:0]       tail_reg  [PRIORITY_LEVELS];
    logic [LINK_W-1:0]       tail_next [PRIORITY_LEVELS];
    logic [SLOT_W-1:0]       cur_reg, cur_next;
    logic                    cur_valid_reg, cur_valid_next;
    logic                    sys_halt_reg, sys_halt_next;

    // Latched request
    op_t                     op_reg, op_next;
    logic [PRI_W-1:0]        preq_reg, preq_next;
    logic                    pgiven_reg, pgiven_next;
    logic [SLOT_W-1:0]       tgt_reg, tgt_next;
    logic                    tgt_ok_reg, tgt_ok_next;
    logic [SLOT_W-1:0]       caller_reg, caller_next;
    logic                    had_reg, had_next;
    logic [SLOT_W-1:0]       new_reg, new_next;

    // Result under construction
    logic [SLOT_W-1:0]       res_slot_reg, res_slot_next;
    logic                    res_tv_reg, res_tv_next;
    logic [RV_W-1:0]         res_rv_reg, res_rv_next;
    logic                    res_wr_reg, res_wr_next;
    logic                    res_halt_reg, res_halt_next;

    // Output stage
    logic                    out_valid_reg, out_valid_next;
    logic [TID_W-1:0]        out_thread_reg, out_thread_next;
    logic                    out_tv_reg, out_tv_next;
    logic [RV_W-1:0]         out_rv_reg, out_rv_next;
    logic                    out_wr_reg, out_wr_next;
    logic                    out_halt_reg, out_halt_next;

    // Helper decode
    logic                    free_found;
    logic [SLOT_W-1:0]       free_idx;
    logic                    scan_found;
    logic [PRI_W-1:0]        scan_lvl;
    logic [SLOT_W-1:0]       q_slot;
    logic                    q_ok;
    logic [PRI_W-1:0]        q_pri;
    logic [LINK_W-1:0]       q_tail;
    logic [PRI_W-1:0]        t_pri;

    // First free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Lowest-numbered nonempty queue
    always_comb
    begin
        scan_found = 1'b0;
        scan_lvl   = '0;
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--)
        begin
            if (head_reg[i] != NIL_LINK)
            begin
                scan_found = 1'b1;
                scan_lvl   = PRI_W'(i);
            end
        end
    end

    // Slot picked by the queue commands
    always_comb
    begin
        case (cmd)
            CMD_QUEUE_TGT:
            begin
                q_slot = tgt_reg;
                q_ok   = tgt_ok_reg;
            end
            CMD_QUEUE_NEW:
            begin
                q_slot = new_reg;
                q_ok   = 1'b1;
            end
            default:
            begin
                q_slot = caller_reg;
                q_ok   = 1'b1;
            end
        endcase
        q_pri  = pri_reg[q_slot];
        q_tail = tail_reg[q_pri];
        t_pri  = pri_reg[caller_reg];
    end

    // Command execution
    always_comb
    begin
        in_use_next     = in_use_reg;
        ready_next      = ready_reg;
        pri_next        = pri_reg;
        link_next       = link_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        cur_valid_next  = cur_valid_reg;
        sys_halt_next   = sys_halt_reg;
        op_next         = op_reg;
        preq_next       = preq_reg;
        pgiven_next     = pgiven_reg;
        tgt_next        = tgt_reg;
        tgt_ok_next     = tgt_ok_reg;
        caller_next     = caller_reg;
        had_next        = had_reg;
        new_next        = new_reg;
        res_slot_next   = res_slot_reg;
        res_tv_next     = res_tv_reg;
        res_rv_next     = res_rv_reg;
        res_wr_next     = res_wr_reg;
        res_halt_next   = res_halt_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        out_thread_next = out_thread_reg;
        out_tv_next     = out_tv_reg;
        out_rv_next     = out_rv_reg;
        out_wr_next     = out_wr_reg;
        out_halt_next   = out_halt_reg;

        unique case (cmd) inside
            CMD_NONE:
            begin
            end
            CMD_LATCH:
            begin
                op_next       = op_t'(operation);
                preq_next     = clamp_pri(priority_req);
                pgiven_next   = priority_given;
                tgt_next      = SLOT_W'(target_thread);
                tgt_ok_next   = int'(target_thread) < THREAD_SLOTS;
                caller_next   = cur_reg;
                had_next      = cur_valid_reg;
                res_slot_next = '0;
                res_tv_next   = 1'b0;
                res_rv_next   = '0;
                res_wr_next   = 1'b0;
                res_halt_next = sys_halt_reg;
            end
            CMD_TAKE:
            begin
                // caller sits at the head of its queue
                if (cur_valid_reg && ready_reg[caller_reg])
                begin
                    head_next[t_pri] = link_reg[caller_reg];
                    if (link_reg[caller_reg] == NIL_LINK)
                        tail_next[t_pri] = NIL_LINK;
                    ready_next[caller_reg] = 1'b0;
                    link_next[caller_reg]  = NIL_LINK;
                end
                case (op_reg) inside
                    OP_RUN:              res_wr_next = had_reg;
                    OP_EXIT, OP_SOFTERR: res_wr_next = 1'b0;
                    default:             res_wr_next = 1'b1;
                endcase
                if (op_reg == OP_GETID)
                    res_rv_next = RV_W'(caller_reg);
            end
            CMD_QUEUE_CUR, CMD_QUEUE_TGT, CMD_QUEUE_NEW:
            begin
                // append to the tail unless already queued
                if (q_ok && !ready_reg[q_slot])
                begin
                    if (q_tail != NIL_LINK)
                        link_next[q_tail[SLOT_W-1:0]] = LINK_W'(q_slot);
                    else
                        head_next[q_pri] = LINK_W'(q_slot);
                    tail_next[q_pri]   = LINK_W'(q_slot);
                    ready_next[q_slot] = 1'b1;
                end
            end
            CMD_CLEAR_CUR:
            begin
                in_use_next[caller_reg] = 1'b0;
                ready_next[caller_reg]  = 1'b0;
                pri_next[caller_reg]    = '0;
                link_next[caller_reg]   = NIL_LINK;
            end
            CMD_CREATE:
            begin
                in_use_next[free_idx] = 1'b1;
                ready_next[free_idx]  = 1'b0;
                pri_next[free_idx]    = preq_reg;
                link_next[free_idx]   = NIL_LINK;
                cur_next              = free_idx;
                cur_valid_next        = 1'b1;
                new_next              = free_idx;
                res_rv_next           = RV_W'(free_idx);
            end
            CMD_RUN_FAIL:
            begin
                res_rv_next = '1;
            end
            CMD_CHPRI:
            begin
                res_rv_next = RV_W'(pri_reg[caller_reg]);
                if (pgiven_reg)
                    pri_next[caller_reg] = preq_reg;
            end
            CMD_SCAN:
            begin
                if (scan_found)
                begin
                    cur_next       = head_reg[scan_lvl][SLOT_W-1:0];
                    cur_valid_next = 1'b1;
                    res_slot_next  = head_reg[scan_lvl][SLOT_W-1:0];
                    res_tv_next    = 1'b1;
                end
                else
                begin
                    sys_halt_next  = 1'b1;
                    cur_valid_next = 1'b0;
                    res_halt_next  = 1'b1;
                end
            end
            CMD_LOAD_OUT:
            begin
                out_valid_next  = 1'b1;
                out_thread_next = TID_W'(res_slot_reg);
                out_tv_next     = res_tv_reg;
                out_rv_next     = res_rv_reg;
                out_wr_next     = res_wr_reg;
                out_halt_next   = res_halt_reg;
            end
            default:
            begin
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            ready_reg     <= '0;
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                pri_reg[i]  <= '0;
                link_reg[i] <= NIL_LINK;
            end
            for (int i = 0; i < PRIORITY_LEVELS; i++)
            begin
                head_reg[i] <= NIL_LINK;
                tail_reg[i] <= NIL_LINK;
            end
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            sys_halt_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_use_reg    <= in_use_next;
            ready_reg     <= ready_next;
            pri_reg       <= pri_next;
            link_reg      <= link_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            sys_halt_reg  <= sys_halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        preq_reg       <= preq_next;
        pgiven_reg     <= pgiven_next;
        tgt_reg        <= tgt_next;
        tgt_ok_reg     <= tgt_ok_next;
        caller_reg     <= caller_next;
        had_reg        <= had_next;
        new_reg        <= new_next;
        res_slot_reg   <= res_slot_next;
        res_tv_reg     <= res_tv_next;
        res_rv_reg     <= res_rv_next;
        res_wr_reg     <= res_wr_next;
        res_halt_reg   <= res_halt_next;
        out_thread_reg <= out_thread_next;
        out_tv_reg     <= out_tv_next;
        out_rv_reg     <= out_rv_next;
        out_wr_reg     <= out_wr_next;
        out_halt_reg   <= out_halt_next;
    end

    // Status to the controller
    assign status.op         = op_reg;
    assign status.had_caller = had_reg;
    assign status.halted     = sys_halt_reg;
    assign status.free_found = free_found;
    assign status.out_busy   = out_valid_reg & ~out_ready;

    assign out_valid      = out_valid_reg;
    assign next_thread    = out_thread_reg;
    assign thread_valid   = out_tv_reg;
    assign result_value   = out_rv_reg;
    assign result_written = out_wr_reg;
    assign halted         = out_halt_reg;

endmodule

[sv/prqs_ctrl.sv]
// Scheduler controller: sequences the per-request steps on the datapath.
module prqs_ctrl
    import prqs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  prqs_status_t status,
    output cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_STEP1,
        S_STEP2,
        S_STEP3,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Step sequence per operation
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = CMD_LATCH;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // halted, or no caller for anything but run: ignore
                if (status.halted || (!status.had_caller && status.op != OP_RUN))
                    state_next = S_FINISH;
                else
                begin
                    cmd        = CMD_TAKE;
                    state_next = S_STEP1;
                end
            end
            S_STEP1:
            begin
                state_next = S_SCAN;
                case (status.op) inside
                    OP_RUN:
                    begin
                        if (!status.free_found)
                            cmd = CMD_RUN_FAIL;
                        else
                        begin
                            cmd        = status.had_caller ? CMD_QUEUE_CUR : CMD_NONE;
                            state_next = S_STEP2;
                        end
                    end
                    OP_EXIT, OP_SOFTERR: cmd = CMD_CLEAR_CUR;
                    OP_WAIT, OP_GETID:   cmd = CMD_QUEUE_CUR;
                    OP_WAKEUP:
                    begin
                        cmd        = CMD_QUEUE_CUR;
                        state_next = S_STEP2;
                    end
                    OP_CHPRI:
                    begin
                        cmd        = CMD_CHPRI;
                        state_next = S_STEP2;
                    end
                    default:             cmd = CMD_NONE;
                endcase
            end
            S_STEP2:
            begin
                state_next = S_SCAN;
                case (status.op)
                    OP_RUN:
                    begin
                        cmd        = CMD_CREATE;
                        state_next = S_STEP3;
                    end
                    OP_WAKEUP: cmd = CMD_QUEUE_TGT;
                    OP_CHPRI:  cmd = CMD_QUEUE_CUR;
                    default:   cmd = CMD_NONE;
                endcase
            end
            S_STEP3:
            begin
                cmd        = CMD_QUEUE_NEW;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd        = CMD_SCAN;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // wait for the output stage to free up
                if (!status.out_busy)
                begin
                    cmd        = CMD_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[sv/priority_ready_queue_scheduler_unit.sv]
// Top level of the fixed-priority ready-queue thread scheduler.
// Usage:
//   Input channel (in_valid/in_ready) carries one trap request from the
//   running thread: operation, priority_req, priority_given, target_thread.
//   Output channel (out_valid/out_ready) returns one result per request:
//   the thread picked to run next, the value for the caller, and halt state.
// Timing:
//   A request is taken only while the controller is idle. An ignored request
//   goes straight to its result; a processed one first steps through its
//   table updates (run is longest: take, requeue caller, create slot,
//   queue new slot, priority scan). The controller steps through one table
//   update per cycle.
//   The next request is taken in the cycle after the result is loaded, even
//   while that result still waits in the output register.
// Reset: all slots free, all queues empty, no current thread, not halted.
// Stall: if the last result still waits in the output register (out_ready
//   low) when a new one is done, the controller holds it; no request is lost.
module priority_ready_queue_scheduler_unit
    import prqs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OP_W-1:0]        operation,
    input  logic [PREQ_W-1:0]      priority_req,
    input  logic                   priority_given,
    input  logic [TID_W-1:0]       target_thread,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [TID_W-1:0]       next_thread,
    output logic                   thread_valid,
    output logic signed [RV_W-1:0] result_value,
    output logic                   result_written,
    output logic                   halted
);

    cmd_t         cmd;
    prqs_status_t status;

    // Step sequencer
    prqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Tables, queues and result path
    prqs_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (operation),
        .priority_req   (priority_req),
        .priority_given (priority_given),
        .target_thread  (target_thread),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .next_thread    (next_thread),
        .thread_valid   (thread_valid),
        .result_value   (result_value),
        .result_written (result_written),
        .halted         (halted)
    );

endmodule

[sv/prqs_checker.sv]
// Port-level checker for the scheduler and its bind to the top level.
module prqs_checker
    import prqs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [OP_W-1:0]        operation,
    input logic [PREQ_W-1:0]      priority_req,
    input logic                   priority_given,
    input logic [TID_W-1:0]       target_thread,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [TID_W-1:0]       next_thread,
    input logic                   thread_valid,
    input logic signed [RV_W-1:0] result_value,
    input logic                   result_written,
    input logic                   halted
);

    logic seen_halt_reg;

    // Remember a delivered halt result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_halt_reg <= 1'b0;
        else if (out_valid && out_ready && halted)
            seen_halt_reg <= 1'b1;
    end

    // Waiting request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(operation)
            && $stable(priority_req) && $stable(priority_given)
            && $stable(target_thread))
        else $error("waiting request changed");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_thread)
            && $stable(thread_valid) && $stable(result_value)
            && $stable(result_written) && $stable(halted))
        else $error("stalled result changed");

    // One request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request accepted while busy");

    // Halt is final
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_halt_reg |-> halted && !thread_valid)
        else $error("result after halt is not halted");

    // A halted result names no thread
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halted |-> !thread_valid && next_thread == '0)
        else $error("halted result carries a thread");

endmodule

bind priority_ready_queue_scheduler_unit prqs_checker u_prqs_checker (.*);
